// ===== sv/mmh_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmh_pkg
// Shared types and constants for the streaming MurmurHash2 block.
// ----------------------------------------------------------------------------
package mmh_pkg;

    localparam logic [31:0] MixMul    = 32'h5bd1e995;
    localparam int          MixShift  = 24;
    localparam int          FinShiftA = 13;
    localparam int          FinShiftB = 15;

    localparam int CmdDepth = 4;
    localparam int CmdPtrW  = $clog2(CmdDepth);

    // One command per request that needs work in the back end.
    typedef struct packed {
        logic        open;
        logic [31:0] init;
        logic        mix;
        logic        fin;
        logic        tail;
        logic [31:0] word;
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_K1,
        S_K2,
        S_HMIX,
        S_TAIL,
        S_FIN,
        S_OUT
    } t_state;

endpackage

// ===== sv/mmh_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmh_front
// Holds the seed, packs bytes into words and issues back-end commands.
// ----------------------------------------------------------------------------
module mmh_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [31:0]   i_cfg_wdata,
    input  logic          i_accept,
    input  logic [7:0]    i_data_byte,
    input  logic          i_byte_present,
    input  logic          i_last_item,
    input  logic [31:0]   i_string_length,
    output logic          o_cmd_push,
    output mmh_pkg::t_cmd o_cmd
);
    import mmh_pkg::*;

    logic [31:0] r_seed;
    logic        r_open, n_open;
    logic [1:0]  r_phase, n_phase;
    logic [31:0] r_word, n_word;

    logic        w_open_now;
    logic [1:0]  w_phase;
    logic [31:0] w_word;
    logic [31:0] w_merged;
    logic        w_mix;

    always_comb begin
        w_open_now = !r_open;
        w_phase    = w_open_now ? 2'd0 : r_phase;
        w_word     = w_open_now ? 32'd0 : r_word;
        w_merged   = w_word | ({24'd0, i_data_byte} << {w_phase, 3'b000});
        w_mix      = i_byte_present && (w_phase == 2'd3);

        n_open  = 1'b1;
        n_phase = w_phase;
        n_word  = w_word;
        if (i_byte_present) begin
            n_phase = w_phase + 2'd1;
            n_word  = w_mix ? 32'd0 : w_merged;
        end

        o_cmd.open = w_open_now;
        o_cmd.init = r_seed ^ i_string_length;
        o_cmd.mix  = w_mix;
        o_cmd.fin  = i_last_item;
        o_cmd.tail = i_last_item && (n_phase != 2'd0);
        o_cmd.word = (i_byte_present) ? w_merged : w_word;

        if (i_last_item) begin
            n_open  = 1'b0;
            n_phase = 2'd0;
            n_word  = 32'd0;
        end

        o_cmd_push = i_accept && (w_open_now || w_mix || i_last_item);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed  <= 32'd0;
            r_open  <= 1'b0;
            r_phase <= 2'd0;
            r_word  <= 32'd0;
        end else begin
            if (i_cfg_we) begin
                r_seed <= i_cfg_wdata;
            end
            if (i_accept) begin
                r_open  <= n_open;
                r_phase <= n_phase;
                r_word  <= n_word;
            end
        end
    end

endmodule

// ===== sv/mmh_cmd_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmh_cmd_fifo
// Short show-ahead queue of commands between the front and back ends.
// ----------------------------------------------------------------------------
module mmh_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mmh_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output mmh_pkg::t_cmd o_cmd,
    output logic          o_full,
    output logic          o_empty
);
    import mmh_pkg::*;

    t_cmd               r_mem [CmdDepth];
    logic [CmdPtrW-1:0] r_wptr;
    logic [CmdPtrW-1:0] r_rptr;
    logic [CmdPtrW:0]   r_count;

    assign o_full  = (r_count == (CmdPtrW+1)'(CmdDepth));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== sv/mmh_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmh_back
// Sequencer around one shared multiplier that mixes words and finalizes.
// ----------------------------------------------------------------------------
module mmh_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_empty,
    input  mmh_pkg::t_cmd i_cmd,
    output logic          o_cmd_pop,
    input  logic          i_pop,
    output logic          o_empty,
    output logic [31:0]   o_hash_value
);
    import mmh_pkg::*;

    t_state      r_state, n_state;
    logic [31:0] r_h, n_h;
    logic [31:0] r_k, n_k;
    logic        r_fin, n_fin;
    logic        r_tail, n_tail;
    logic        r_out_valid, n_out_valid;
    logic [31:0] r_hash, n_hash;

    logic [31:0] w_mul_a;
    logic [31:0] w_prod;

    always_comb begin
        case (r_state)
            S_K1:    w_mul_a = r_k;
            S_K2:    w_mul_a = r_k ^ (r_k >> MixShift);
            S_HMIX:  w_mul_a = r_h;
            S_TAIL:  w_mul_a = r_h ^ r_k;
            S_FIN:   w_mul_a = r_h ^ (r_h >> FinShiftA);
            default: w_mul_a = r_h;
        endcase
        w_prod = w_mul_a * MixMul;
    end

    always_comb begin
        n_state     = r_state;
        n_h         = r_h;
        n_k         = r_k;
        n_fin       = r_fin;
        n_tail      = r_tail;
        n_out_valid = r_out_valid && !i_pop;
        n_hash      = r_hash;
        o_cmd_pop   = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (!i_cmd_empty) begin
                    o_cmd_pop = 1'b1;
                    n_h       = i_cmd.open ? i_cmd.init : r_h;
                    n_k       = i_cmd.word;
                    n_fin     = i_cmd.fin;
                    n_tail    = i_cmd.tail;
                    if (i_cmd.mix) begin
                        n_state = S_K1;
                    end else if (i_cmd.fin) begin
                        n_state = i_cmd.tail ? S_TAIL : S_FIN;
                    end
                end
            end
            S_K1: begin
                n_k     = w_prod;
                n_state = S_K2;
            end
            S_K2: begin
                n_k     = w_prod;
                n_state = S_HMIX;
            end
            S_HMIX: begin
                n_h     = w_prod ^ r_k;
                n_state = r_fin ? (r_tail ? S_TAIL : S_FIN) : S_IDLE;
            end
            S_TAIL: begin
                n_h     = w_prod;
                n_state = S_FIN;
            end
            S_FIN: begin
                n_h     = w_prod;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || i_pop) begin
                    n_out_valid = 1'b1;
                    n_hash      = r_h ^ (r_h >> FinShiftB);
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_h    <= n_h;
        r_k    <= n_k;
        r_fin  <= n_fin;
        r_tail <= n_tail;
        r_hash <= n_hash;
    end

    assign o_empty      = !r_out_valid;
    assign o_hash_value = r_hash;

endmodule

// ===== sv/murmur2_string_hash.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// murmur2_string_hash
// Streaming 32-bit MurmurHash2 of byte strings, one byte per request.
// ----------------------------------------------------------------------------
// Input side is a queue: a request is taken when push is high and full is
// low. The first request of a string carries its total length, which is
// XORed with the seed; last_item closes the string and byte_present tells
// whether data_byte is a real byte. The seed is written through i_cfg_we
// and i_cfg_wdata and is used from the next string that opens.
// Result side is a queue too: while empty is low the hash is on
// o_hash_value and is taken when pop is high.
// The front end takes one request per cycle while its four-entry command
// queue has room. The back end runs one 32x32 multiplier: a full word is
// mixed in states K1, K2 and HMIX; a closing request passes through TAIL
// when bytes are left over, then FIN and OUT. Long strings run at one byte
// per cycle while results are taken. A stalled result holds the back end,
// the queue then fills and full rises. Reset clears the seed, the queue and
// any partial string.
// ----------------------------------------------------------------------------
module murmur2_string_hash (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_present,
    input  logic        i_last_item,
    input  logic [31:0] i_string_length,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_hash_value
);
    import mmh_pkg::*;

    logic w_accept;
    logic w_cmd_push;
    logic w_cmd_pop;
    logic w_cmd_full;
    logic w_cmd_empty;
    t_cmd w_cmd_in;
    t_cmd w_cmd_out;

    assign full     = w_cmd_full;
    assign w_accept = push && !w_cmd_full;

    mmh_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_accept        (w_accept),
        .i_data_byte     (i_data_byte),
        .i_byte_present  (i_byte_present),
        .i_last_item     (i_last_item),
        .i_string_length (i_string_length),
        .o_cmd_push      (w_cmd_push),
        .o_cmd           (w_cmd_in)
    );

    mmh_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd_push),
        .i_cmd   (w_cmd_in),
        .i_pop   (w_cmd_pop),
        .o_cmd   (w_cmd_out),
        .o_full  (w_cmd_full),
        .o_empty (w_cmd_empty)
    );

    mmh_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_empty  (w_cmd_empty),
        .i_cmd        (w_cmd_out),
        .o_cmd_pop    (w_cmd_pop),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_hash_value (o_hash_value)
    );

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_push |-> !w_cmd_full)
        else $error("Command pushed into a full queue.");

    a_pop_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_pop |-> !w_cmd_empty)
        else $error("Command popped from an empty queue.");

    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("Queues not cleared by reset.");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the streaming MurmurHash2 string hash block.
// ----------------------------------------------------------------------------
// Byte strings are pushed one request per byte. A predictor class keeps its
// own copy of the seed and of the partial hash. It queues the expected hash
// when a request closes a string, and compares every popped result with the
// oldest queued hash. A directed set of strings comes first. Random strings
// follow in phases with different seeds and different amounts of idling on
// both sides. One phase holds off the result side long enough to back up the
// input side.
// ----------------------------------------------------------------------------
module tb;
    import mmh_pkg::*;

    class hash_scoreboard;
        logic [31:0] seed;
        logic [31:0] partial_hash;
        logic [31:0] word_acc;
        logic [1:0]  bytes_held;
        bit          string_active;
        logic [31:0] hash_q[$];
        int          errors;

        function new();
            seed          = '0;
            partial_hash  = '0;
            word_acc      = '0;
            bytes_held    = '0;
            string_active = 1'b0;
            errors        = 0;
        endfunction

        function void write_seed(logic [31:0] value);
            seed = value;
        endfunction

        function int pending();
            return hash_q.size();
        endfunction

        function void note_request(logic [7:0] data, logic present, logic last,
                                   logic [31:0] len);
            logic [31:0] k;
            logic [31:0] h;
            if (!string_active) begin
                partial_hash  = seed ^ len;
                word_acc      = '0;
                bytes_held    = '0;
                string_active = 1'b1;
            end
            if (present) begin
                word_acc   = word_acc | ({24'd0, data} << (8 * bytes_held));
                bytes_held = bytes_held + 2'd1;
                if (bytes_held == 2'd0) begin
                    k = word_acc * MixMul;
                    k = k ^ (k >> MixShift);
                    k = k * MixMul;
                    partial_hash = (partial_hash * MixMul) ^ k;
                    word_acc = '0;
                end
            end
            if (last) begin
                h = partial_hash;
                if (bytes_held != 2'd0) begin
                    h = h ^ word_acc;
                    h = h * MixMul;
                end
                h = h ^ (h >> FinShiftA);
                h = h * MixMul;
                h = h ^ (h >> FinShiftB);
                hash_q.push_back(h);
                partial_hash  = '0;
                word_acc      = '0;
                bytes_held    = '0;
                string_active = 1'b0;
            end
        endfunction

        function void check_hash(logic [31:0] actual);
            logic [31:0] want;
            if (hash_q.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("ERROR: unexpected hash_value %08h at %0t", actual, $time);
                end
                return;
            end
            want = hash_q.pop_front();
            if (actual !== want) begin
                errors++;
                if (errors <= 10) begin
                    $display("ERROR: hash_value expected %08h actual %08h at %0t",
                             want, actual, $time);
                end
            end
        endfunction
    endclass

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_cfg_we        = 1'b0;
    logic [31:0] i_cfg_wdata     = '0;
    logic        push            = 1'b0;
    logic        full;
    logic [7:0]  i_data_byte     = '0;
    logic        i_byte_present  = 1'b0;
    logic        i_last_item     = 1'b0;
    logic [31:0] i_string_length = '0;
    logic        empty;
    logic        pop             = 1'b0;
    logic [31:0] o_hash_value;

    hash_scoreboard sb = new();

    int  idle_pct    = 0;
    int  stall_pct   = 0;
    int  items_sent  = 0;
    bit  hold_req    = 1'b0;
    logic [7:0] string_bytes[$];

    murmur2_string_hash DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .push            (push),
        .full            (full),
        .i_data_byte     (i_data_byte),
        .i_byte_present  (i_byte_present),
        .i_last_item     (i_last_item),
        .i_string_length (i_string_length),
        .empty           (empty),
        .pop             (pop),
        .o_hash_value    (o_hash_value)
    );

    initial begin
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            sb.check_hash(o_hash_value);
        end
    end

    // The result side; a long hold-off is counted here once requested.
    initial begin
        int hold;
        hold = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold     = 300;
                hold_req = 1'b0;
            end
            if (hold > 0) begin
                hold--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    task automatic send_request(input logic [7:0] data, input logic present,
                                input logic last, input logic [31:0] len);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            push        <= 1'b0;
            i_data_byte <= 8'($urandom);
            @(negedge i_clk);
        end
        push            <= 1'b1;
        i_data_byte     <= data;
        i_byte_present  <= present;
        i_last_item     <= last;
        i_string_length <= len;
        do begin
            @(posedge i_clk);
        end while (full);
        sb.note_request(data, present, last, len);
        items_sent++;
    endtask

    task automatic stop_sending();
        @(negedge i_clk);
        push <= 1'b0;
    endtask

    // Sends string_bytes as one string. Filler requests carry no byte.
    task automatic send_string(input logic [31:0] claimed, input bit tail_no_byte,
                               input int filler_pct);
        bit          first;
        int          n;
        logic [31:0] len;
        first = 1'b1;
        n     = string_bytes.size();
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < filler_pct) begin
                len = first ? claimed : $urandom;
                send_request(8'($urandom), 1'b0, 1'b0, len);
                first = 1'b0;
            end
            len = first ? claimed : $urandom;
            send_request(string_bytes[i], 1'b1, !tail_no_byte && (i == n - 1), len);
            first = 1'b0;
        end
        if (n == 0 || tail_no_byte) begin
            len = first ? claimed : $urandom;
            send_request(8'($urandom), 1'b0, 1'b1, len);
        end
    endtask

    task automatic random_string();
        int n;
        logic [31:0] claimed;
        n = ($urandom_range(9) == 0) ? $urandom_range(64) : $urandom_range(12);
        string_bytes.delete();
        for (int i = 0; i < n; i++) begin
            string_bytes.push_back(8'($urandom));
        end
        claimed = ($urandom_range(9) == 0) ? $urandom : n;
        send_string(claimed, $urandom_range(3) == 0,
                    ($urandom_range(4) == 0) ? 20 : 0);
    endtask

    task automatic wait_results_done();
        int n;
        n = 0;
        while (sb.pending() != 0 && n < 20000) begin
            @(posedge i_clk);
            n++;
        end
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_seed(input logic [31:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.write_seed(value);
    endtask

    task automatic run_phase(input logic [31:0] seed, input int sender_idle,
                             input int receiver_stall, input int n_items,
                             input bit long_hold, input bit mid_pause);
        int target;
        write_seed(seed);
        idle_pct  = sender_idle;
        stall_pct = receiver_stall;
        target    = items_sent + n_items;
        if (long_hold) begin
            hold_req = 1'b1;
        end
        while (items_sent < target) begin
            random_string();
            if (mid_pause && items_sent >= target - n_items / 2) begin
                stop_sending();
                wait_results_done();
                mid_pause = 1'b0;
            end
        end
        stop_sending();
        wait_results_done();
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_seed(32'h0000_0000);

        string_bytes.delete();
        send_string(32'h0000_0000, 1'b0, 0);
        send_string(32'hFFFF_FFFF, 1'b0, 0);
        string_bytes = '{8'hFF};
        send_string(32'd1, 1'b0, 0);
        string_bytes = '{8'h00, 8'h80, 8'hFF};
        send_string(32'd3, 1'b1, 0);
        string_bytes = '{8'h61, 8'h62, 8'h63, 8'h64};
        send_string(32'd4, 1'b0, 0);
        string_bytes = '{8'h01, 8'h02, 8'h03, 8'h04, 8'h05};
        send_string(32'd5, 1'b0, 0);
        string_bytes = '{8'hAA, 8'h55};
        send_string(32'd1000, 1'b0, 0);
        send_request(8'h5A, 1'b0, 1'b0, 32'd2);
        send_request(8'h12, 1'b1, 1'b0, 32'h0BAD_F00D);
        send_request(8'hC3, 1'b0, 1'b0, 32'hFFFF_FFFF);
        send_request(8'h34, 1'b1, 1'b0, 32'h0000_0000);
        send_request(8'h00, 1'b0, 1'b1, 32'h1234_5678);
        stop_sending();
        wait_results_done();

        run_phase(32'hFFFF_FFFF, 0, 0, 320, 1'b1, 1'b0);
        run_phase($urandom, 65, 0, 320, 1'b0, 1'b0);
        run_phase(32'h8000_0001, 0, 65, 320, 1'b0, 1'b1);
        run_phase($urandom, 37, 37, 320, 1'b0, 1'b0);
        run_phase(32'h0000_0000, 0, 0, 320, 1'b0, 1'b0);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
